// ===== rtl/kdlp_pkg.sv =====
// Package with the shared types, constants and next-state function of the key debouncer.
package kdlp_pkg;

	// Field widths fixed by the interface.
	localparam int KEY_W       = 3;
	localparam int KIND_W      = 2;
	localparam int TIME_W      = 16;
	localparam int TICK_W      = 10;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// Default number of keys.
	localparam int NUM_KEYS_DEF = 7;

	// Depth of the event queue, in items.
	localparam int EVQ_DEPTH = 4;

	// Register reset values.
	localparam logic [TIME_W-1:0] DEBOUNCE_TIME_RST   = 16'd50;
	localparam logic [TIME_W-1:0] LONG_PRESS_TIME_RST = 16'd1000;
	localparam logic [TICK_W-1:0] TICK_MS_RST         = 10'd10;

	// Saturation limit of the held time.
	localparam logic [TIME_W-1:0] HELD_MAX = 16'hFFFF;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TIME = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS         = 2'd2;

	// Event kinds.
	localparam logic [KIND_W-1:0] KIND_PRESS      = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LONG_PRESS = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LONG_CLICK = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLICK      = 2'd3;

	// Per-key state word kept in the state memory.
	typedef struct packed {
		logic              pressed;
		logic              debouncing;
		logic              long_reported;
		logic [TIME_W-1:0] debounce_remaining;
		logic [TIME_W-1:0] held_time;
	} key_state_t;

	// Configuration as seen by the update logic.
	typedef struct packed {
		logic [TIME_W-1:0] debounce_time;
		logic [TIME_W-1:0] long_press_time;
		logic [TICK_W-1:0] tick_ms;
	} cfg_t;

	// One queued item: its key and the events it caused.
	// With two_events set, a long click precedes the final event.
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic              two_events;
		logic [KIND_W-1:0] kind;
	} evq_entry_t;

	// Result of one state update.
	typedef struct packed {
		key_state_t        state;
		logic              has_event;
		logic              two_events;
		logic [KIND_W-1:0] kind;
	} upd_t;

	// Next state and events of one key for one sampled level.
	function automatic upd_t key_update(key_state_t s, logic level, cfg_t c);
		upd_t              r;
		logic [TIME_W:0]   sum;
		logic [TIME_W-1:0] held;
		r.state      = s;
		r.has_event  = 1'b0;
		r.two_events = 1'b0;
		r.kind       = KIND_PRESS;
		sum          = {1'b0, s.held_time} + {{(TIME_W + 1 - TICK_W){1'b0}}, c.tick_ms};
		held         = sum[TIME_W] ? HELD_MAX : sum[TIME_W-1:0];
		if (level) begin
			if (!s.pressed) begin
				r.state.pressed            = 1'b1;
				r.state.debouncing         = 1'b1;
				r.state.debounce_remaining = c.debounce_time;
			end else if (s.debouncing) begin
				if (s.debounce_remaining > {{(TIME_W - TICK_W){1'b0}}, c.tick_ms}) begin
					r.state.debounce_remaining = s.debounce_remaining
						- {{(TIME_W - TICK_W){1'b0}}, c.tick_ms};
				end else begin
					r.state.debouncing = 1'b0;
					r.has_event        = 1'b1;
					r.kind             = KIND_PRESS;
				end
			end else if ((c.long_press_time != '0) && !s.long_reported) begin
				r.state.held_time = held;
				if (held >= c.long_press_time) begin
					r.state.long_reported = 1'b1;
					r.has_event           = 1'b1;
					r.kind                = KIND_LONG_PRESS;
				end
			end
		end else if (s.pressed) begin
			r.state.pressed = 1'b0;
			if (s.debouncing) begin
				r.state.debouncing = 1'b0;
			end else begin
				r.state.debounce_remaining = '0;
				r.state.held_time          = '0;
				r.state.long_reported      = 1'b0;
				r.two_events               = s.long_reported;
				r.has_event                = 1'b1;
				r.kind                     = KIND_CLICK;
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/kdlp_in_if.sv =====
// Channel interface for key samples.
interface kdlp_in_if;
	logic                         valid;
	logic                         ready;
	logic [kdlp_pkg::KEY_W-1:0]   key_index;
	logic                         level;

	modport source (output valid, output key_index, output level, input ready);
	modport sink (input valid, input key_index, input level, output ready);
endinterface

// ===== rtl/kdlp_out_if.sv =====
// Channel interface for key events.
interface kdlp_out_if;
	logic                         valid;
	logic                         ready;
	logic [kdlp_pkg::KEY_W-1:0]   event_key;
	logic [kdlp_pkg::KIND_W-1:0]  event_kind;
	logic                         last;

	modport source (output valid, output event_key, output event_kind, output last, input ready);
	modport sink (input valid, input event_key, input event_kind, input last, output ready);
endinterface

// ===== rtl/kdlp_state_mem.sv =====
// Per-key state memory with registered read and valid bits that read as zero state.
module kdlp_state_mem #(
	parameter int NUM_KEYS = kdlp_pkg::NUM_KEYS_DEF,
	localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output kdlp_pkg::key_state_t rd_data,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  kdlp_pkg::key_state_t wr_data
);

	kdlp_pkg::key_state_t mem [NUM_KEYS];
	logic [NUM_KEYS-1:0]  valid_q;
	kdlp_pkg::key_state_t rd_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Valid bits: an entry never written holds the reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== rtl/kdlp_event_q.sv =====
// Event queue that holds one entry per item and emits one or two event beats per entry.
module kdlp_event_q (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  kdlp_pkg::evq_entry_t push_data,
	input  logic                 reserve,
	output logic                 can_take,
	kdlp_out_if.source           event_out
);

	localparam int PW = $clog2(kdlp_pkg::EVQ_DEPTH);
	localparam int CW = $clog2(kdlp_pkg::EVQ_DEPTH + 1);

	kdlp_pkg::evq_entry_t entries_q [kdlp_pkg::EVQ_DEPTH];
	logic [PW-1:0]        wr_ptr_q;
	logic [PW-1:0]        rd_ptr_q;
	logic [CW-1:0]        count_q;
	logic                 phase_q;
	kdlp_pkg::evq_entry_t head;
	logic                 beat;
	logic                 pop;

	assign head = entries_q[rd_ptr_q];
	assign beat = event_out.valid && event_out.ready;
	assign pop  = beat && (!head.two_events || phase_q);

	// Room for a new item, counting the one still in the update stage.
	assign can_take = (count_q + CW'(reserve)) < CW'(kdlp_pkg::EVQ_DEPTH);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers, fill count and the beat phase within a two-event entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			phase_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= PW'((32'(wr_ptr_q) + 1) % kdlp_pkg::EVQ_DEPTH);
			end
			if (pop) begin
				rd_ptr_q <= PW'((32'(rd_ptr_q) + 1) % kdlp_pkg::EVQ_DEPTH);
				phase_q  <= 1'b0;
			end else if (beat) begin
				phase_q <= 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Output beat: the long click comes first where there are two events.
	assign event_out.valid      = (count_q != '0);
	assign event_out.event_key  = head.key;
	assign event_out.event_kind = (head.two_events && !phase_q) ? kdlp_pkg::KIND_LONG_CLICK
		: head.kind;
	assign event_out.last       = !head.two_events || phase_q;

endmodule

// ===== rtl/key_debounce_long_press_top.sv =====
// Top level of the key debouncer with long-press detection.
// Takes one key sample per clock cycle and sustains that rate while the event
// queue has room: a sample reads its key's state from the state memory in the
// cycle it is accepted, and the next cycle updates the state and writes it
// back. Back-to-back samples of the same key take the updated state through a
// bypass register. A release that ends a reported long press gives two event
// beats (long click, then click). A key index at or above NUM_KEYS is dropped
// without effect. Registers are to be written only while the block is idle:
// the user must keep to this, as the block itself does not enforce it. They
// reset to a debounce time of 50 ms, a long-press time of 1000 ms and a tick
// of 10 ms. The state memory needs no clearing pass after reset.
module key_debounce_long_press_top #(
	parameter int NUM_KEYS = kdlp_pkg::NUM_KEYS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	kdlp_in_if.sink                           key_in,
	kdlp_out_if.source                        event_out,
	input  logic                              cfg_we,
	input  logic [kdlp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kdlp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	kdlp_pkg::cfg_t               cfg_q;
	logic                         accept;
	logic                         can_take;
	logic [AW-1:0]                in_addr;
	logic                         v_s1;
	logic                         in_range_s1;
	logic [kdlp_pkg::KEY_W-1:0]   key_s1;
	logic                         level_s1;
	logic                         use_byp_s1;
	kdlp_pkg::key_state_t         byp_q;
	kdlp_pkg::key_state_t         rd_data;
	kdlp_pkg::key_state_t         cur_state;
	kdlp_pkg::upd_t               upd;
	logic                         wr_en;
	kdlp_pkg::evq_entry_t         push_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time   <= kdlp_pkg::DEBOUNCE_TIME_RST;
			cfg_q.long_press_time <= kdlp_pkg::LONG_PRESS_TIME_RST;
			cfg_q.tick_ms         <= kdlp_pkg::TICK_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kdlp_pkg::CFG_DEBOUNCE_TIME: begin
					cfg_q.debounce_time <= cfg_data;
				end
				kdlp_pkg::CFG_LONG_PRESS_TIME: begin
					cfg_q.long_press_time <= cfg_data;
				end
				kdlp_pkg::CFG_TICK_MS: begin
					cfg_q.tick_ms <= cfg_data[kdlp_pkg::TICK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign key_in.ready = can_take;
	assign accept       = key_in.valid && key_in.ready;
	assign in_addr      = AW'(key_in.key_index);

	// Update stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	// Update stage payload; the bypass catches a write to the key just read.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1      <= key_in.key_index;
			level_s1    <= key_in.level;
			in_range_s1 <= (32'(key_in.key_index) < NUM_KEYS);
			use_byp_s1  <= wr_en && (key_s1 == key_in.key_index);
			byp_q       <= upd.state;
		end
	end

	kdlp_state_mem #(
		.NUM_KEYS (NUM_KEYS)
	) u_state_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (in_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (AW'(key_s1)),
		.wr_data (upd.state)
	);

	// Read-modify-write of the key state.
	assign cur_state = use_byp_s1 ? byp_q : rd_data;
	assign upd       = kdlp_pkg::key_update(cur_state, level_s1, cfg_q);
	assign wr_en     = v_s1 && in_range_s1;

	assign push_data.key        = key_s1;
	assign push_data.two_events = upd.two_events;
	assign push_data.kind       = upd.kind;

	kdlp_event_q u_event_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (wr_en && upd.has_event),
		.push_data (push_data),
		.reserve   (v_s1),
		.can_take  (can_take),
		.event_out (event_out)
	);

endmodule
